// ----- src/lmfr_pkg.sv -----
// ----------------------------------------------------------------------------
// lmfr_pkg
// shared types and constants for the led matrix frame refresher
// ----------------------------------------------------------------------------
package lmfr_pkg;

    // item kinds
    localparam logic [1:0] KIND_PIXEL   = 2'd0;
    localparam logic [1:0] KIND_REFRESH = 2'd1;
    localparam logic [1:0] KIND_INIT    = 2'd2;

    // driver register addresses and control data
    localparam logic [3:0] ADDR_TEST      = 4'h0F;
    localparam logic [3:0] ADDR_INTENSITY = 4'h0A;
    localparam logic [3:0] ADDR_SCANLIMIT = 4'h0B;
    localparam logic [3:0] ADDR_SHUTDOWN  = 4'h0C;
    localparam logic [7:0] SCAN_ALL       = 8'h07;
    localparam logic [7:0] DISPLAY_ON     = 8'h01;

    localparam logic [3:0] BRIGHT_RESET = 4'd8;
    localparam int         ROWS_DEF     = 8;

    // frame index: 0..3 control frames, 4.. row frames
    localparam int         IDX_W      = 4;
    localparam logic [3:0] IDX_TEST   = 4'd0;
    localparam logic [3:0] IDX_INTENS = 4'd1;
    localparam logic [3:0] IDX_SCAN   = 4'd2;
    localparam logic [3:0] IDX_SHUT   = 4'd3;
    localparam logic [3:0] IDX_ROW0   = 4'd4;

    typedef struct packed {
        logic pix_we;      // apply pixel write
        logic start;       // begin a frame run
        logic start_init;  // run is an init sequence
        logic load;        // load next frame into output register
    } t_cmd;

    typedef struct packed {
        logic last;        // frame index points at final frame of the run
    } t_sts;

endpackage

// ----- src/lmfr_ctrl.sv -----
// ----------------------------------------------------------------------------
// lmfr_ctrl
// controller: accepts items, sequences frame loads, owns output valid
// ----------------------------------------------------------------------------
module lmfr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  logic [1:0]      i_kind,
    input  logic            i_refresh_after,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output lmfr_pkg::t_cmd  o_cmd,
    input  lmfr_pkg::t_sts  i_sts
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic in_xfer;
    logic run_req;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign in_xfer     = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        case (i_kind)
            lmfr_pkg::KIND_PIXEL:   run_req = i_refresh_after;
            lmfr_pkg::KIND_REFRESH: run_req = 1'b1;
            lmfr_pkg::KIND_INIT:    run_req = 1'b1;
            default:                run_req = 1'b0;
        endcase
    end

    always_comb begin
        o_cmd.pix_we     = in_xfer && (i_kind == lmfr_pkg::KIND_PIXEL);
        o_cmd.start      = in_xfer && run_req;
        o_cmd.start_init = (i_kind == lmfr_pkg::KIND_INIT);
        // output register free or being drained
        o_cmd.load       = (r_state == S_RUN) && (!r_out_valid || !i_out_stall);
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (o_cmd.start) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (o_cmd.load) begin
                    n_out_valid = 1'b1;
                    if (i_sts.last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_load_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> r_state == S_RUN)
        else $error("frame load outside a run");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> r_state == S_RUN)
        else $error("run start did not enter run state");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load && i_sts.last) |=> (r_state == S_IDLE && r_out_valid))
        else $error("final frame load did not end the run");

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_out_valid)
        else $error("loaded frame not marked valid");

endmodule

// ----- src/lmfr_dp.sv -----
// ----------------------------------------------------------------------------
// lmfr_dp
// datapath: frame buffer, brightness register, frame index, output register
// ----------------------------------------------------------------------------
module lmfr_dp #(
    parameter int ROWS = lmfr_pkg::ROWS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [3:0]      i_cfg_brightness,
    input  logic [3:0]      i_column,
    input  logic [2:0]      i_row_index,
    input  logic            i_pixel_on,
    input  lmfr_pkg::t_cmd  i_cmd,
    output lmfr_pkg::t_sts  o_sts,
    output logic [3:0]      o_register_address,
    output logic [7:0]      o_far_data,
    output logic [7:0]      o_near_data,
    output logic            o_last_frame
);

    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [lmfr_pkg::IDX_W-1:0] IDX_LAST =
        lmfr_pkg::IDX_W'(ROWS + 3);

    logic [7:0] r_far  [ROWS];
    logic [7:0] r_near [ROWS];
    logic [3:0] r_bright;
    logic [lmfr_pkg::IDX_W-1:0] r_idx;
    logic       r_blank;

    logic [3:0] r_addr;
    logic [7:0] r_fd;
    logic [7:0] r_nd;
    logic       r_last;

    logic [3:0] row_off;
    logic [RW-1:0] rd_row;
    logic [RW-1:0] wr_row;
    logic       wr_ok;
    logic [7:0] mask;
    logic [3:0] n_addr;
    logic [7:0] n_fd;
    logic [7:0] n_nd;

    assign wr_ok   = ({1'b0, i_row_index} < 4'(ROWS));
    assign wr_row  = i_row_index[RW-1:0];
    assign mask    = 8'h80 >> i_column[2:0];
    assign row_off = r_idx - lmfr_pkg::IDX_ROW0;
    assign rd_row  = row_off[RW-1:0];
    assign o_sts.last = (r_idx == IDX_LAST);

    always_comb begin
        case (r_idx)
            lmfr_pkg::IDX_TEST: begin
                n_addr = lmfr_pkg::ADDR_TEST;
                n_fd   = 8'h00;
                n_nd   = 8'h00;
            end
            lmfr_pkg::IDX_INTENS: begin
                n_addr = lmfr_pkg::ADDR_INTENSITY;
                n_fd   = {4'h0, r_bright};
                n_nd   = {4'h0, r_bright};
            end
            lmfr_pkg::IDX_SCAN: begin
                n_addr = lmfr_pkg::ADDR_SCANLIMIT;
                n_fd   = lmfr_pkg::SCAN_ALL;
                n_nd   = lmfr_pkg::SCAN_ALL;
            end
            lmfr_pkg::IDX_SHUT: begin
                n_addr = lmfr_pkg::ADDR_SHUTDOWN;
                n_fd   = lmfr_pkg::DISPLAY_ON;
                n_nd   = lmfr_pkg::DISPLAY_ON;
            end
            default: begin
                // row frames address 1..ROWS
                n_addr = row_off + 4'd1;
                n_fd   = r_blank ? 8'h00 : r_far[rd_row];
                n_nd   = r_blank ? 8'h00 : r_near[rd_row];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ROWS; i++) begin
                r_far[i]  <= 8'h00;
                r_near[i] <= 8'h00;
            end
            r_bright <= lmfr_pkg::BRIGHT_RESET;
        end else begin
            if (i_cfg_we) begin
                r_bright <= i_cfg_brightness;
            end
            if (i_cmd.pix_we && wr_ok) begin
                if (!i_column[3]) begin
                    r_far[wr_row] <= i_pixel_on ? (r_far[wr_row] | mask)
                                                : (r_far[wr_row] & ~mask);
                end else begin
                    r_near[wr_row] <= i_pixel_on ? (r_near[wr_row] | mask)
                                                 : (r_near[wr_row] & ~mask);
                end
            end
        end
    end

    // frame index and output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_idx   <= i_cmd.start_init ? lmfr_pkg::IDX_TEST : lmfr_pkg::IDX_ROW0;
            r_blank <= i_cmd.start_init;
        end else if (i_cmd.load) begin
            r_idx <= r_idx + 4'd1;
        end
        if (i_cmd.load) begin
            r_addr <= n_addr;
            r_fd   <= n_fd;
            r_nd   <= n_nd;
            r_last <= o_sts.last;
        end
    end

    assign o_register_address = r_addr;
    assign o_far_data         = r_fd;
    assign o_near_data        = r_nd;
    assign o_last_frame       = r_last;

endmodule

// ----- src/led_matrix_frame_refresher_unit.sv -----
// ----------------------------------------------------------------------------
// led_matrix_frame_refresher_unit
// 16xROWS frame buffer for two chained 8x8 led matrix drivers, emits frames
// ----------------------------------------------------------------------------
// channel  | direction | handshake                  | payload
// in       | input     | i_in_valid / o_in_stall    | kind column row_index pixel_on refresh_after
// out      | output    | o_out_valid / i_out_stall  | register_address far/near data last_frame
// cfg      | input     | i_cfg_we                   | i_cfg_brightness
//
// an item is taken when it is valid and the controller is idle; a refresh then loads
// ROWS frames and an init ROWS+4 frames, one per cycle into the output register while it is free
// stalls on the output hold the controller; the input stalls for the whole run
// synchronous active-low reset clears the buffer and sets brightness to 8
// ----------------------------------------------------------------------------
module led_matrix_frame_refresher_unit #(
    parameter int ROWS = lmfr_pkg::ROWS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_brightness,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_kind,
    input  logic [3:0] i_column,
    input  logic [2:0] i_row_index,
    input  logic       i_pixel_on,
    input  logic       i_refresh_after,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [3:0] o_register_address,
    output logic [7:0] o_far_data,
    output logic [7:0] o_near_data,
    output logic       o_last_frame
);

    lmfr_pkg::t_cmd cmd;
    lmfr_pkg::t_sts sts;

    lmfr_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_kind          (i_kind),
        .i_refresh_after (i_refresh_after),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_cmd           (cmd),
        .i_sts           (sts)
    );

    lmfr_dp #(
        .ROWS (ROWS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_brightness   (i_cfg_brightness),
        .i_column           (i_column),
        .i_row_index        (i_row_index),
        .i_pixel_on         (i_pixel_on),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .o_register_address (o_register_address),
        .o_far_data         (o_far_data),
        .o_near_data        (o_near_data),
        .o_last_frame       (o_last_frame)
    );

endmodule

// ----- test/led_matrix_frame_refresher_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_matrix_frame_refresher_unit_tb
// sends pixel, refresh and init requests with random gaps on both sides and
// keeps its own copy of the two row banks. every chain frame is predicted when
// its request is taken and checked in order. runs at brightness 8, 15, 0 and
// one random setting.
// ----------------------------------------------------------------------------
module led_matrix_frame_refresher_unit_tb;

    localparam int         ROWS          = lmfr_pkg::ROWS_DEF;
    localparam int         SETTLE_CYCLES = 20;
    localparam logic [1:0] KIND_UNUSED   = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] column;
        logic [2:0] row_index;
        logic       pixel_on;
        logic       refresh_after;
    } t_pixel_req;

    typedef struct packed {
        logic [3:0] addr;
        logic [7:0] far_data;
        logic [7:0] near_data;
        logic       last;
    } t_chain_frame;

    logic       clk            = 1'b0;
    logic       rst_n          = 1'b0;
    logic       cfg_we         = 1'b0;
    logic [3:0] cfg_brightness = 4'd0;
    logic       in_valid       = 1'b0;
    t_pixel_req in_req         = '0;
    logic       in_stall;
    logic       out_valid;
    logic       out_stall      = 1'b0;
    logic [3:0] out_addr;
    logic [7:0] out_far;
    logic [7:0] out_near;
    logic       out_last;

    t_pixel_req   pending_reqs[$];
    t_chain_frame expected_frames[$];

    // local copy of the frame buffer and intensity setting
    logic [7:0] far_bank [ROWS] = '{default: 8'h00};
    logic [7:0] near_bank[ROWS] = '{default: 8'h00};
    logic [3:0] brightness_now  = lmfr_pkg::BRIGHT_RESET;

    int idle_pct    = 31;
    int error_count = 0;

    led_matrix_frame_refresher_unit #(
        .ROWS(ROWS)
    ) dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_brightness   (cfg_brightness),
        .i_in_valid         (in_valid),
        .o_in_stall         (in_stall),
        .i_kind             (in_req.kind),
        .i_column           (in_req.column),
        .i_row_index        (in_req.row_index),
        .i_pixel_on         (in_req.pixel_on),
        .i_refresh_after    (in_req.refresh_after),
        .o_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .o_register_address (out_addr),
        .o_far_data         (out_far),
        .o_near_data        (out_near),
        .o_last_frame       (out_last)
    );

    always #5 clk = ~clk;

    task automatic push_rows(input logic blank);
        for (int r = 0; r < ROWS; r++) begin
            expected_frames.push_back('{addr:      4'(r + 1),
                                        far_data:  blank ? 8'h00 : far_bank[r],
                                        near_data: blank ? 8'h00 : near_bank[r],
                                        last:      (r == ROWS - 1)});
        end
    endtask

    // update the banks and queue the frames one request produces
    task automatic predict_frames(input t_pixel_req req);
        logic [7:0] mask;
        mask = 8'h80 >> req.column[2:0];
        case (req.kind)
            lmfr_pkg::KIND_PIXEL: begin
                if (int'(req.row_index) < ROWS) begin
                    if (req.column[3]) begin
                        near_bank[req.row_index] = req.pixel_on ?
                            (near_bank[req.row_index] | mask) :
                            (near_bank[req.row_index] & ~mask);
                    end else begin
                        far_bank[req.row_index] = req.pixel_on ?
                            (far_bank[req.row_index] | mask) :
                            (far_bank[req.row_index] & ~mask);
                    end
                end
                if (req.refresh_after) begin
                    push_rows(1'b0);
                end
            end
            lmfr_pkg::KIND_REFRESH: begin
                push_rows(1'b0);
            end
            lmfr_pkg::KIND_INIT: begin
                expected_frames.push_back('{lmfr_pkg::ADDR_TEST, 8'h00, 8'h00, 1'b0});
                expected_frames.push_back('{lmfr_pkg::ADDR_INTENSITY,
                                            {4'h0, brightness_now},
                                            {4'h0, brightness_now}, 1'b0});
                expected_frames.push_back('{lmfr_pkg::ADDR_SCANLIMIT, lmfr_pkg::SCAN_ALL,
                                            lmfr_pkg::SCAN_ALL, 1'b0});
                expected_frames.push_back('{lmfr_pkg::ADDR_SHUTDOWN, lmfr_pkg::DISPLAY_ON,
                                            lmfr_pkg::DISPLAY_ON, 1'b0});
                // blanking rows, buffer itself is kept
                push_rows(1'b1);
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    // request driver
    always @(posedge clk) begin
        logic       next_valid;
        t_pixel_req next_req;
        next_valid = in_valid;
        next_req   = in_req;
        if (!rst_n) begin
            next_valid = 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                predict_frames(in_req);
                next_valid = 1'b0;
            end
            if (!next_valid && pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
                next_req   = pending_reqs.pop_front();
                next_valid = 1'b1;
            end
        end
        in_valid <= next_valid;
        in_req   <= next_req;
    end

    // frame monitor
    always @(posedge clk) begin
        t_chain_frame want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_frames.size() == 0) begin
                error_count++;
                $display("%0t: unexpected frame, expected none, actual addr %0d far %0d near %0d",
                         $time, out_addr, out_far, out_near);
            end else begin
                want = expected_frames.pop_front();
                check_field("register_address", want.addr, out_addr);
                check_field("far_data", want.far_data, out_far);
                check_field("near_data", want.near_data, out_near);
                check_field("last_frame", want.last, out_last);
            end
        end
        out_stall <= rst_n && ($urandom_range(99) < idle_pct);
    end

    task automatic queue_req(input logic [1:0] kind, input logic [3:0] column,
                             input logic [2:0] row_index, input logic pixel_on,
                             input logic refresh_after);
        pending_reqs.push_back('{kind, column, row_index, pixel_on, refresh_after});
    endtask

    task automatic queue_random(input int count);
        t_pixel_req req;
        int         pick;
        repeat (count) begin
            req.column        = 4'($urandom_range(15));
            req.row_index     = 3'($urandom_range(7));
            req.pixel_on      = 1'($urandom_range(1));
            req.refresh_after = 1'($urandom_range(1));
            pick = $urandom_range(99);
            if (pick < 60) begin
                req.kind          = lmfr_pkg::KIND_PIXEL;
                req.refresh_after = ($urandom_range(99) < 30);
            end else if (pick < 75) begin
                req.kind = lmfr_pkg::KIND_REFRESH;
            end else if (pick < 88) begin
                req.kind = lmfr_pkg::KIND_INIT;
            end else begin
                req.kind = KIND_UNUSED;
            end
            pending_reqs.push_back(req);
        end
    endtask

    // waits until every request is taken and every frame is back, then lets the bench settle
    task automatic wait_idle();
        do @(negedge clk);
        while (pending_reqs.size() != 0 || in_valid || expected_frames.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_brightness(input logic [3:0] value);
        @(posedge clk);
        cfg_we         <= 1'b1;
        cfg_brightness <= value;
        @(posedge clk);
        cfg_we         <= 1'b0;
        brightness_now = value;
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset brightness, corner pixels, clears, ignored fields
        queue_req(lmfr_pkg::KIND_INIT,    4'd0,  3'd0, 1'b0, 1'b0);
        queue_req(lmfr_pkg::KIND_REFRESH, 4'd0,  3'd0, 1'b0, 1'b0);
        queue_req(lmfr_pkg::KIND_PIXEL,   4'd0,  3'd0, 1'b1, 1'b1);
        queue_req(lmfr_pkg::KIND_PIXEL,   4'd15, 3'd7, 1'b1, 1'b0);
        queue_req(lmfr_pkg::KIND_PIXEL,   4'd7,  3'd0, 1'b1, 1'b0);
        queue_req(lmfr_pkg::KIND_PIXEL,   4'd8,  3'd7, 1'b1, 1'b1);
        queue_req(KIND_UNUSED,            4'd15, 3'd7, 1'b1, 1'b1);
        queue_req(lmfr_pkg::KIND_REFRESH, 4'd15, 3'd7, 1'b1, 1'b1);
        queue_req(lmfr_pkg::KIND_PIXEL,   4'd0,  3'd0, 1'b0, 1'b1);
        queue_req(lmfr_pkg::KIND_PIXEL,   4'd15, 3'd7, 1'b0, 1'b0);
        queue_req(lmfr_pkg::KIND_INIT,    4'd15, 3'd7, 1'b1, 1'b1);
        queue_req(lmfr_pkg::KIND_REFRESH, 4'd0,  3'd0, 1'b0, 1'b0);
        queue_req(lmfr_pkg::KIND_PIXEL,   4'd3,  3'd4, 1'b1, 1'b0);
        queue_req(lmfr_pkg::KIND_PIXEL,   4'd12, 3'd2, 1'b1, 1'b0);
        queue_req(lmfr_pkg::KIND_PIXEL,   4'd3,  3'd4, 1'b1, 1'b1);
        queue_req(lmfr_pkg::KIND_PIXEL,   4'd9,  3'd5, 1'b0, 1'b1);
        queue_req(KIND_UNUSED,            4'd0,  3'd0, 1'b0, 1'b0);
        queue_req(lmfr_pkg::KIND_INIT,    4'd0,  3'd0, 1'b0, 1'b0);
        wait_idle();

        write_brightness(4'd15);
        queue_req(lmfr_pkg::KIND_INIT, 4'd0, 3'd0, 1'b0, 1'b0);
        queue_random(85);
        wait_idle();

        // stretch with no gaps on either side
        write_brightness(4'd0);
        idle_pct = 0;
        queue_req(lmfr_pkg::KIND_INIT, 4'd0, 3'd0, 1'b0, 1'b0);
        queue_random(70);
        wait_idle();
        idle_pct = 31;

        write_brightness(4'($urandom_range(15)));
        queue_req(lmfr_pkg::KIND_INIT, 4'd0, 3'd0, 1'b0, 1'b0);
        queue_random(85);
        wait_idle();

        if (error_count == 0) begin
            $display("led_matrix_frame_refresher_unit_tb OK");
        end else begin
            $display("led_matrix_frame_refresher_unit_tb NOT OK");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("led_matrix_frame_refresher_unit_tb NOT OK");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/lmfr_pkg.sv
src/lmfr_ctrl.sv
src/lmfr_dp.sv
src/led_matrix_frame_refresher_unit.sv
test/led_matrix_frame_refresher_unit_tb.sv
